// ===== rtl/core/gcs_pkg.sv =====
// Shared types and constants for the guide correction solver.
`timescale 1ns / 1ps
package gcs_pkg;

   localparam int FRAC_BITS = 16;
   localparam int DATA_W    = 32;
   localparam int NUM_REGS  = 6;
   localparam int IDX_W     = 3;
   localparam int DEN_W     = 64;
   localparam int REM_W     = 98;
   localparam int Q_W       = 34;
   localparam int NUM_CELLS = Q_W;

   localparam logic [IDX_W-1:0] REG_RA_GAIN_X  = 3'd0;
   localparam logic [IDX_W-1:0] REG_DEC_GAIN_X = 3'd1;
   localparam logic [IDX_W-1:0] REG_DRIFT_X    = 3'd2;
   localparam logic [IDX_W-1:0] REG_RA_GAIN_Y  = 3'd3;
   localparam logic [IDX_W-1:0] REG_DEC_GAIN_Y = 3'd4;
   localparam logic [IDX_W-1:0] REG_DRIFT_Y    = 3'd5;

   typedef struct packed {
      logic signed [DATA_W-1:0] ra_gain_x;
      logic signed [DATA_W-1:0] dec_gain_x;
      logic signed [DATA_W-1:0] drift_x;
      logic signed [DATA_W-1:0] ra_gain_y;
      logic signed [DATA_W-1:0] dec_gain_y;
      logic signed [DATA_W-1:0] drift_y;
   } calib_type;

   typedef struct packed {
      logic             nocal;
      logic             neg_ra;
      logic             neg_dec;
      logic [REM_W-1:0] rem_ra;
      logic [REM_W-1:0] rem_dec;
      logic [DEN_W-1:0] den;
      logic [Q_W-1:0]   q_ra;
      logic [Q_W-1:0]   q_dec;
   } div_slot_type;

endpackage

// ===== rtl/core/gcs_front.sv =====
// Front pipeline: drift removal, determinant and Cramer numerators.
`timescale 1ns / 1ps
module gcs_front (
   input  logic                          clock,
   input  logic                          reset,
   input  gcs_pkg::calib_type            calib,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [31:0]            offset_x,
   input  logic signed [31:0]            offset_y,
   input  logic [31:0]                   interval,
   output logic                          out_valid,
   input  logic                          out_ready,
   output gcs_pkg::div_slot_type         out_slot
);
   import gcs_pkg::*;

   logic [4:0] v_ff, v_in, rdy;

   // stage 1: 32x32 products
   logic signed [31:0] ox_ff, oy_ff;
   logic signed [63:0] p04_ff, p13_ff, p04_in, p13_in;
   logic signed [64:0] px_ff, py_ff, px_in, py_in;
   // stage 2: determinant and drift-free offsets
   logic signed [64:0] det2_ff, dx_ff, dy_ff, det2_in, dx_in, dy_in, oxw, oyw;
   // stage 3: split partial products
   logic signed [64:0] det3_ff;
   logic signed [32:0] dxh, dyh;
   logic signed [64:0] m_xl4_ff, m_xh4_ff, m_yl1_ff, m_yh1_ff;
   logic signed [64:0] m_yl0_ff, m_yh0_ff, m_xl3_ff, m_xh3_ff;
   logic signed [64:0] m_xl4_in, m_xh4_in, m_yl1_in, m_yh1_in;
   logic signed [64:0] m_yl0_in, m_yh0_in, m_xl3_in, m_xh3_in;
   // stage 4: numerators
   logic signed [64:0]      det4_ff;
   logic signed [REM_W-1:0] nra_ff, ndec_ff, nra_in, ndec_in;
   // stage 5: magnitudes for the divider
   div_slot_type slot_ff, slot_in;
   logic signed [REM_W-1:0] ra_abs, dec_abs;
   logic signed [64:0]      det_abs;

   always_comb begin
      rdy[4] = !v_ff[4] || out_ready;
      rdy[3] = !v_ff[3] || rdy[4];
      rdy[2] = !v_ff[2] || rdy[3];
      rdy[1] = !v_ff[1] || rdy[2];
      rdy[0] = !v_ff[0] || rdy[1];
      v_in[0] = rdy[0] ? in_valid : v_ff[0];
      v_in[1] = rdy[1] ? v_ff[0]  : v_ff[1];
      v_in[2] = rdy[2] ? v_ff[1]  : v_ff[2];
      v_in[3] = rdy[3] ? v_ff[2]  : v_ff[3];
      v_in[4] = rdy[4] ? v_ff[3]  : v_ff[4];
   end

   assign in_ready  = rdy[0];
   assign out_valid = v_ff[4];
   assign out_slot  = slot_ff;

   always_comb begin
      p04_in = calib.ra_gain_x * calib.dec_gain_y;
      p13_in = calib.dec_gain_x * calib.ra_gain_y;
      px_in  = $signed({1'b0, interval}) * calib.drift_x;
      py_in  = $signed({1'b0, interval}) * calib.drift_y;

      oxw     = 65'(ox_ff);
      oyw     = 65'(oy_ff);
      det2_in = 65'(p04_ff) - 65'(p13_ff);
      dx_in   = (oxw <<< FRAC_BITS) - px_ff;
      dy_in   = (oyw <<< FRAC_BITS) - py_ff;

      dxh      = $signed(dx_ff[64:32]);
      dyh      = $signed(dy_ff[64:32]);
      m_xl4_in = $signed({1'b0, dx_ff[31:0]}) * calib.dec_gain_y;
      m_xh4_in = dxh * calib.dec_gain_y;
      m_yl1_in = $signed({1'b0, dy_ff[31:0]}) * calib.dec_gain_x;
      m_yh1_in = dyh * calib.dec_gain_x;
      m_yl0_in = $signed({1'b0, dy_ff[31:0]}) * calib.ra_gain_x;
      m_yh0_in = dyh * calib.ra_gain_x;
      m_xl3_in = $signed({1'b0, dx_ff[31:0]}) * calib.ra_gain_y;
      m_xh3_in = dxh * calib.ra_gain_y;

      nra_in  = (REM_W'(m_xh4_ff) <<< 32) + REM_W'(m_xl4_ff)
              - (REM_W'(m_yh1_ff) <<< 32) - REM_W'(m_yl1_ff);
      ndec_in = (REM_W'(m_yh0_ff) <<< 32) + REM_W'(m_yl0_ff)
              - (REM_W'(m_xh3_ff) <<< 32) - REM_W'(m_xl3_ff);

      ra_abs  = nra_ff[REM_W-1]  ? -nra_ff  : nra_ff;
      dec_abs = ndec_ff[REM_W-1] ? -ndec_ff : ndec_ff;
      det_abs = det4_ff[64] ? -det4_ff : det4_ff;
      slot_in.nocal   = (det4_ff == '0);
      slot_in.neg_ra  = nra_ff[REM_W-1] ^ det4_ff[64];
      slot_in.neg_dec = ndec_ff[REM_W-1] ^ det4_ff[64];
      slot_in.rem_ra  = ra_abs;
      slot_in.rem_dec = dec_abs;
      slot_in.den     = det_abs[DEN_W-1:0];
      slot_in.q_ra    = '0;
      slot_in.q_dec   = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
      if (rdy[0]) begin
         ox_ff  <= offset_x;
         oy_ff  <= offset_y;
         p04_ff <= p04_in;
         p13_ff <= p13_in;
         px_ff  <= px_in;
         py_ff  <= py_in;
      end
      if (rdy[1]) begin
         det2_ff <= det2_in;
         dx_ff   <= dx_in;
         dy_ff   <= dy_in;
      end
      if (rdy[2]) begin
         det3_ff  <= det2_ff;
         m_xl4_ff <= m_xl4_in;
         m_xh4_ff <= m_xh4_in;
         m_yl1_ff <= m_yl1_in;
         m_yh1_ff <= m_yh1_in;
         m_yl0_ff <= m_yl0_in;
         m_yh0_ff <= m_yh0_in;
         m_xl3_ff <= m_xl3_in;
         m_xh3_ff <= m_xh3_in;
      end
      if (rdy[3]) begin
         det4_ff <= det3_ff;
         nra_ff  <= nra_in;
         ndec_ff <= ndec_in;
      end
      if (rdy[4]) begin
         slot_ff <= slot_in;
      end
   end

endmodule

// ===== rtl/core/gcs_div_cell.sv =====
// One restoring-division cell: settles one quotient bit of both corrections.
`timescale 1ns / 1ps
module gcs_div_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  up_valid,
   output logic                  up_ready,
   input  gcs_pkg::div_slot_type up_slot,
   output logic                  dn_valid,
   input  logic                  dn_ready,
   output gcs_pkg::div_slot_type dn_slot
);
   import gcs_pkg::*;

   logic         valid_ff;
   div_slot_type slot_ff, slot_in;
   logic [REM_W-1:0] dsh, sub_ra, sub_dec;
   logic             ge_ra, ge_dec;

   // divisor sits at the top quotient weight; the remainder walks left instead
   always_comb begin
      dsh     = REM_W'({up_slot.den, {(Q_W-1){1'b0}}});
      ge_ra   = up_slot.rem_ra  >= dsh;
      ge_dec  = up_slot.rem_dec >= dsh;
      sub_ra  = ge_ra  ? up_slot.rem_ra  - dsh : up_slot.rem_ra;
      sub_dec = ge_dec ? up_slot.rem_dec - dsh : up_slot.rem_dec;
      slot_in         = up_slot;
      slot_in.rem_ra  = sub_ra  << 1;
      slot_in.rem_dec = sub_dec << 1;
      slot_in.q_ra    = {up_slot.q_ra[Q_W-2:0], ge_ra};
      slot_in.q_dec   = {up_slot.q_dec[Q_W-2:0], ge_dec};
   end

   assign up_ready = !valid_ff || dn_ready;
   assign dn_valid = valid_ff;
   assign dn_slot  = slot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
      if (up_ready) begin
         slot_ff <= slot_in;
      end
   end

endmodule

// ===== rtl/core/guide_correction_solver.sv =====
// Guide correction solver: drift removal and 2x2 Cramer solve with a cell-chain divider.
// An accepted req beat passes through the 5 front stages and the 34 divider cells,
// then the output register, before it leaves as its rsp beat.
// Throughput: one item per cycle unless rsp_tready stalls; one quotient bit per cell.
// Reset clears all stage valids and the six calibration registers to zero.
// Every stage stalls only when the stage after it is full and held.
`timescale 1ns / 1ps
module guide_correction_solver (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [95:0]  req_tdata,   // offset_x, offset_y, interval
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [63:0]  rsp_tdata,   // correction_ra, correction_dec
   output logic [1:0]   rsp_tuser,   // no_calibration, saturated
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_data
);
   import gcs_pkg::*;

   calib_type calib_ff;

   logic         fr_valid;
   div_slot_type fr_slot;
   logic         ch_valid [NUM_CELLS+1];
   logic         ch_ready [NUM_CELLS+1];
   div_slot_type ch_slot  [NUM_CELLS+1];

   logic         rsp_valid_ff;
   logic [31:0]  ra_ff, dec_ff, ra_in, dec_in;
   logic         nocal_ff, sat_ff, sat_in;
   logic         out_ready;
   logic         ovf_ra, ovf_dec;
   div_slot_type last;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         calib_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_RA_GAIN_X:  calib_ff.ra_gain_x  <= csr_data;
            REG_DEC_GAIN_X: calib_ff.dec_gain_x <= csr_data;
            REG_DRIFT_X:    calib_ff.drift_x    <= csr_data;
            REG_RA_GAIN_Y:  calib_ff.ra_gain_y  <= csr_data;
            REG_DEC_GAIN_Y: calib_ff.dec_gain_y <= csr_data;
            REG_DRIFT_Y:    calib_ff.drift_y    <= csr_data;
            default: ;
         endcase
      end
   end

   gcs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .calib     (calib_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .offset_x  ($signed(req_tdata[31:0])),
      .offset_y  ($signed(req_tdata[63:32])),
      .interval  (req_tdata[95:64]),
      .out_valid (fr_valid),
      .out_ready (ch_ready[0]),
      .out_slot  (fr_slot)
   );

   assign ch_valid[0] = fr_valid;
   assign ch_slot[0]  = fr_slot;

   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      gcs_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (ch_valid[i]),
         .up_ready (ch_ready[i]),
         .up_slot  (ch_slot[i]),
         .dn_valid (ch_valid[i+1]),
         .dn_ready (ch_ready[i+1]),
         .dn_slot  (ch_slot[i+1])
      );
   end

   assign out_ready            = !rsp_valid_ff || rsp_tready;
   assign ch_ready[NUM_CELLS]  = out_ready;
   assign last                 = ch_slot[NUM_CELLS];

   // saturate the magnitudes; a negative result may reach exactly -2^31
   always_comb begin
      if (last.neg_ra) begin
         ovf_ra = last.q_ra[33] | last.q_ra[32] | (last.q_ra[31] & (|last.q_ra[30:0]));
         ra_in  = ovf_ra ? 32'h8000_0000 : -last.q_ra[31:0];
      end else begin
         ovf_ra = |last.q_ra[33:31];
         ra_in  = ovf_ra ? 32'h7FFF_FFFF : last.q_ra[31:0];
      end
      if (last.neg_dec) begin
         ovf_dec = last.q_dec[33] | last.q_dec[32]
                 | (last.q_dec[31] & (|last.q_dec[30:0]));
         dec_in  = ovf_dec ? 32'h8000_0000 : -last.q_dec[31:0];
      end else begin
         ovf_dec = |last.q_dec[33:31];
         dec_in  = ovf_dec ? 32'h7FFF_FFFF : last.q_dec[31:0];
      end
      sat_in = ovf_ra | ovf_dec;
      if (last.nocal) begin
         ra_in  = '0;
         dec_in = '0;
         sat_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= ch_valid[NUM_CELLS];
      end
      if (out_ready) begin
         ra_ff    <= ra_in;
         dec_ff   <= dec_in;
         nocal_ff <= last.nocal;
         sat_ff   <= sat_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {dec_ff, ra_ff};
   assign rsp_tuser  = {sat_ff, nocal_ff};

`ifndef SYNTHESIS
   a_nocal_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata == '0 && !rsp_tuser[1]))
      else $error("no-calibration beat carries a non-zero correction");
   a_sat_clip: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1]) |->
         (rsp_tdata[31:0] == 32'h7FFF_FFFF || rsp_tdata[31:0] == 32'h8000_0000 ||
          rsp_tdata[63:32] == 32'h7FFF_FFFF || rsp_tdata[63:32] == 32'h8000_0000))
      else $error("saturated beat without a clipped correction");
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid straight after reset");
   a_chain_hold: assert property (@(posedge clock) disable iff (reset)
      (ch_valid[NUM_CELLS] && !out_ready) |=> ch_valid[NUM_CELLS])
      else $error("last divider cell dropped a held result");
`endif

endmodule
